/* design/arcm_pkg.sv */
// Shared types and constants for the alignment region column mask.
`timescale 1ns / 1ps

package arcm_pkg;

    // Field widths fixed by the alignment beat format
    localparam int COL_W     = 10;
    localparam int COUNT_W   = 11;
    localparam int COORD_W   = 32;
    localparam int POS_W     = 34;
    localparam int ROW_BITS  = 32;
    localparam int ROW_SEL_W = COL_W - 5;

    // Maximum number of columns that a column index can address
    localparam int COL_SPAN = 1 << COL_W;

    // First-marked value that means no column is marked yet
    localparam logic [COUNT_W-1:0] NONE_MARK = '1;

    // Configuration register indexes
    localparam logic REG_TARGET_START = 1'b0;
    localparam logic REG_TARGET_STOP  = 1'b1;

    // Trim verdict codes
    localparam logic [1:0] VERDICT_DROP = 2'd0;
    localparam logic [1:0] VERDICT_KEEP = 2'd1;
    localparam logic [1:0] VERDICT_TRIM = 2'd2;

    typedef struct packed {
        logic               block_first;
        logic               block_last;
        logic               row_selected;
        logic               row_first;
        logic [COORD_W-1:0] row_coord;
        logic               reverse_strand;
        logic               is_gap;
        logic [COL_W-1:0]   column;
    } in_beat_t;

    typedef struct packed {
        logic [COUNT_W-1:0] marked_count;
        logic [COUNT_W-1:0] column_count;
        logic [COUNT_W-1:0] leading_unmarked;
        logic [COUNT_W-1:0] trailing_unmarked;
        logic [1:0]         verdict;
    } out_beat_t;

    // One row write into the mark store
    typedef struct packed {
        logic                 en;
        logic [ROW_SEL_W-1:0] row;
        logic [ROW_BITS-1:0]  data;
    } mark_wr_t;

endpackage

/* design/arcm_mark_store.sv */
// Column mark store: rows of mark bits with per-row valid flags and a forwarded read.
`timescale 1ns / 1ps

module arcm_mark_store #(
    parameter int ROWS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [arcm_pkg::ROW_SEL_W-1:0]  rd_row,
    output logic [arcm_pkg::ROW_BITS-1:0]   rd_data,
    input  arcm_pkg::mark_wr_t              wr,
    input  logic                            clear
);
    import arcm_pkg::*;

    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [ROW_BITS-1:0] mem [0:ROWS-1];
    logic [ROWS-1:0]     valid_reg;
    logic [ROWS-1:0]     valid_next;
    logic [ROW_BITS-1:0] rd_data_reg;
    logic [ROW_AW-1:0]   wr_idx;
    logic [ROW_AW-1:0]   rd_idx;

    assign wr_idx  = wr.row[ROW_AW-1:0];
    assign rd_idx  = rd_row[ROW_AW-1:0];
    assign rd_data = rd_data_reg;

    // A block start drops every row at once; a write makes its row live.
    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            valid_next[r] = (clear ? 1'b0 : valid_reg[r]) ||
                            (wr.en && (wr_idx == ROW_AW'(r)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Row memory; a read of the row being written returns the new data.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_idx] <= wr.data;
        end
        if (rd_en)
        begin
            if (wr.en && (wr_idx == rd_idx))
            begin
                rd_data_reg <= wr.data;
            end
            else if (valid_next[rd_idx])
            begin
                rd_data_reg <= mem[rd_idx];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

endmodule

/* design/alignment_region_column_mask.sv */
// Top level of the alignment region column mask.
//
// Usage: one alignment character arrives per input beat (in_valid, in_stall,
// in_beat). For selected rows the block tracks the genomic position and marks
// every column whose position falls inside [target_start, target_stop]. The
// last beat of a block yields one summary beat on the output channel
// (out_valid, out_stall, out_beat); other beats yield nothing.
// Configuration is written through cfg_write, cfg_index and cfg_data while
// the block is idle.
// A summary beat passes from the working-stage register into the output register.
// Throughput: one input beat per cycle while in_stall is low, set by the read-
// modify-write of a mark row, whose read is forwarded from the write in flight.
// Reset clears the position, the counts and all row valid flags, so every
// mark reads as zero; no clearing pass is needed.
// When the receiver stalls, the waiting summary holds in the output register;
// input beats keep flowing until a second summary beat would need that
// register, and then in_stall rises.
`timescale 1ns / 1ps

module alignment_region_column_mask #(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  arcm_pkg::in_beat_t  in_beat,
    output logic                out_valid,
    input  logic                out_stall,
    output arcm_pkg::out_beat_t out_beat,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);
    import arcm_pkg::*;

    localparam int MARK_DEPTH = (MAX_COLUMNS < COL_SPAN) ? MAX_COLUMNS : COL_SPAN;
    localparam int ROWS       = (MARK_DEPTH + ROW_BITS - 1) / ROW_BITS;
    localparam logic [16:0] COL_LIMIT = 17'(MAX_COLUMNS);

    logic               accept;
    logic               s1_adv;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    in_beat_t           s1_beat_reg;
    logic [COORD_W-1:0] target_start_reg;
    logic [COORD_W-1:0] target_stop_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [COUNT_W-1:0] mark_total_reg;
    logic [COUNT_W-1:0] mark_total_next;
    logic [COUNT_W-1:0] first_marked_reg;
    logic [COUNT_W-1:0] first_marked_next;
    logic [COUNT_W-1:0] last_marked_reg;
    logic [COUNT_W-1:0] last_marked_next;
    logic [COUNT_W-1:0] columns_seen_reg;
    logic [COUNT_W-1:0] columns_seen_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_beat_t          out_beat_reg;
    out_beat_t          out_beat_next;

    logic [ROW_BITS-1:0] rd_bits;
    logic [ROW_BITS-1:0] cur_bits;
    mark_wr_t            mark_wr;

    logic               col_ok;
    logic               in_target;
    logic               hit;
    logic [COUNT_W-1:0] col_ext;
    logic [POS_W-1:0]   pos_base;
    logic [COUNT_W-1:0] mt_base;
    logic [COUNT_W-1:0] fm_base;
    logic [COUNT_W-1:0] lm_base;
    logic [COUNT_W-1:0] cs_base;

    // Handshake: the working stage moves on unless its summary has no room.
    assign s1_adv    = s1_valid_reg &&
                       !(s1_beat_reg.block_last && out_valid_reg && out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    // Mark row is fetched as the beat is taken.
    arcm_mark_store #(
        .ROWS (ROWS)
    ) u_mark_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_row  (in_beat.column[COL_W-1:5]),
        .rd_data (rd_bits),
        .wr      (mark_wr),
        .clear   (s1_adv && s1_beat_reg.block_first)
    );

    // Position tracking and target test for the beat in the working stage.
    always_comb
    begin
        col_ext  = {1'b0, s1_beat_reg.column};
        col_ok   = {7'd0, s1_beat_reg.column} < COL_LIMIT;
        pos_base = s1_beat_reg.row_first ? {2'b00, s1_beat_reg.row_coord} : pos_reg;
        in_target = !pos_base[POS_W-1] &&
                    (pos_base >= {2'b00, target_start_reg}) &&
                    (pos_base <= {2'b00, target_stop_reg});
        pos_next = pos_base;
        if (s1_beat_reg.row_selected && !s1_beat_reg.is_gap)
        begin
            if (s1_beat_reg.reverse_strand)
            begin
                pos_next = pos_base - POS_W'(1);
            end
            else
            begin
                pos_next = pos_base + POS_W'(1);
            end
        end
    end

    // Mark check, count update and summary for the beat in the working stage.
    always_comb
    begin
        cur_bits = s1_beat_reg.block_first ? '0 : rd_bits;
        hit = col_ok && s1_beat_reg.row_selected && !s1_beat_reg.is_gap &&
              in_target && !cur_bits[s1_beat_reg.column[4:0]];

        mark_wr.en   = s1_adv && hit;
        mark_wr.row  = s1_beat_reg.column[COL_W-1:5];
        mark_wr.data = cur_bits | (ROW_BITS'(1) << s1_beat_reg.column[4:0]);

        mt_base = s1_beat_reg.block_first ? '0 : mark_total_reg;
        fm_base = s1_beat_reg.block_first ? NONE_MARK : first_marked_reg;
        lm_base = s1_beat_reg.block_first ? '0 : last_marked_reg;
        cs_base = s1_beat_reg.block_first ? '0 : columns_seen_reg;

        columns_seen_next = cs_base;
        if (col_ok && ((col_ext + COUNT_W'(1)) > cs_base))
        begin
            columns_seen_next = col_ext + COUNT_W'(1);
        end

        mark_total_next   = mt_base;
        first_marked_next = fm_base;
        last_marked_next  = lm_base;
        if (hit)
        begin
            mark_total_next = mt_base + COUNT_W'(1);
            if ((fm_base == NONE_MARK) || (col_ext < fm_base))
            begin
                first_marked_next = col_ext;
            end
            if (col_ext > lm_base)
            begin
                last_marked_next = col_ext;
            end
        end

        out_beat_next.marked_count = mark_total_next;
        out_beat_next.column_count = columns_seen_next;
        if (mark_total_next == '0)
        begin
            out_beat_next.leading_unmarked  = columns_seen_next;
            out_beat_next.trailing_unmarked = columns_seen_next;
            out_beat_next.verdict           = VERDICT_DROP;
        end
        else
        begin
            out_beat_next.leading_unmarked  = first_marked_next;
            out_beat_next.trailing_unmarked = columns_seen_next - COUNT_W'(1) -
                                              last_marked_next;
            if ((out_beat_next.leading_unmarked == '0) &&
                (out_beat_next.trailing_unmarked == '0))
            begin
                out_beat_next.verdict = VERDICT_KEEP;
            end
            else
            begin
                out_beat_next.verdict = VERDICT_TRIM;
            end
        end
    end

    // Valid flags of the working stage and the output register.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv && s1_beat_reg.block_last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and block state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            target_start_reg <= '0;
            target_stop_reg  <= '0;
            pos_reg          <= '0;
            mark_total_reg   <= '0;
            first_marked_reg <= NONE_MARK;
            last_marked_reg  <= '0;
            columns_seen_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                if (cfg_index == REG_TARGET_START)
                begin
                    target_start_reg <= cfg_data;
                end
                else
                begin
                    target_stop_reg <= cfg_data;
                end
            end
            if (s1_adv)
            begin
                pos_reg          <= pos_next;
                mark_total_reg   <= mark_total_next;
                first_marked_reg <= first_marked_next;
                last_marked_reg  <= last_marked_next;
                columns_seen_reg <= columns_seen_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_beat_reg <= in_beat;
        end
        if (s1_adv && s1_beat_reg.block_last)
        begin
            out_beat_reg <= out_beat_next;
        end
    end

endmodule

/* test/tb_alignment_region_column_mask.sv */
// Self-checking testbench for the alignment region column mask.
`timescale 1ns / 1ps

module tb_alignment_region_column_mask;
    import arcm_pkg::*;

    // Cycles without any accepted beat before the run is declared hung
    localparam int unsigned HANG_LIMIT = 2000;
    // Quiet cycles granted after the last summary before a register write
    localparam int unsigned SETTLE_CYCLES = 4;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_beat_t    in_beat = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_beat_t   out_beat;
    logic        cfg_write = 1'b0;
    logic        cfg_index = REG_TARGET_START;
    logic [31:0] cfg_data = '0;

    // Characters waiting to be driven and summaries waiting to be seen
    in_beat_t  char_queue[$];
    out_beat_t pending_summaries[$];

    // Mirror of the block: target window, tracked position and block counters
    logic [31:0]         tgt_start = '0;
    logic [31:0]         tgt_stop = '0;
    logic [COL_SPAN-1:0] col_hit = '0;
    logic [POS_W-1:0]    track_pos = '0;
    logic [COUNT_W-1:0]  hit_total = '0;
    logic [COUNT_W-1:0]  hit_lo = NONE_MARK;
    logic [COUNT_W-1:0]  hit_hi = '0;
    logic [COUNT_W-1:0]  span_seen = '0;

    // Bookkeeping
    bit          calm = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned stall_roll;
    int unsigned idle_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned chars_taken = 0;
    int unsigned summaries_checked = 0;
    int unsigned items_queued = 0;
    int unsigned summaries_queued = 0;
    int unsigned settings_used = 0;
    out_beat_t   oldest_summary;

    alignment_region_column_mask dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Pause length for either side: mostly none or short, now and then long.
    function automatic int unsigned pick_pause();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Advance the mirrored state by one accepted character and, on the last
    // character of a block, record the summary it must produce.
    function automatic void track_char(input in_beat_t b);
        out_beat_t s;
        logic      hit;
        if (b.block_first)
        begin
            col_hit = '0;
            hit_total = '0;
            hit_lo = NONE_MARK;
            hit_hi = '0;
            span_seen = '0;
        end
        if (b.row_first)
            track_pos = {2'b00, b.row_coord};

        // Every 10-bit column index is addressable, so no column is dropped.
        if ({1'b0, b.column} + 11'd1 > span_seen)
            span_seen = {1'b0, b.column} + 11'd1;

        if (b.row_selected && !b.is_gap)
        begin
            // A negative position has its top bit set and never matches.
            hit = !track_pos[POS_W-1] && track_pos >= {2'b00, tgt_start}
                  && track_pos <= {2'b00, tgt_stop};
            if (hit && !col_hit[b.column])
            begin
                col_hit[b.column] = 1'b1;
                hit_total = hit_total + 11'd1;
                if (hit_lo == NONE_MARK || {1'b0, b.column} < hit_lo)
                    hit_lo = {1'b0, b.column};
                if ({1'b0, b.column} > hit_hi)
                    hit_hi = {1'b0, b.column};
            end
            track_pos = b.reverse_strand ? track_pos - 1'b1 : track_pos + 1'b1;
        end

        if (b.block_last)
        begin
            s.marked_count = hit_total;
            s.column_count = span_seen;
            if (hit_total == 0)
            begin
                s.leading_unmarked = span_seen;
                s.trailing_unmarked = span_seen;
                s.verdict = VERDICT_DROP;
            end
            else
            begin
                s.leading_unmarked = hit_lo;
                s.trailing_unmarked = span_seen - 11'd1 - hit_hi;
                s.verdict = (s.leading_unmarked == 0 && s.trailing_unmarked == 0)
                            ? VERDICT_KEEP : VERDICT_TRIM;
            end
            pending_summaries.push_back(s);
        end
    endfunction

    function automatic void queue_char(input bit first, input bit last, input bit sel,
                                       input bit rfirst, input logic [31:0] coord,
                                       input bit rev, input bit gap, input int col);
        in_beat_t b;
        b.block_first = first;
        b.block_last = last;
        b.row_selected = sel;
        b.row_first = rfirst;
        b.row_coord = coord;
        b.reverse_strand = rev;
        b.is_gap = gap;
        b.column = col[COL_W-1:0];
        char_queue.push_back(b);
        items_queued++;
        if (last)
            summaries_queued++;
    endfunction

    // A well-formed block: rows walk the columns in order, each row loading
    // its position on column zero. Now and then the block start is left out.
    function automatic int queue_block(input logic [31:0] base);
        int          ncols;
        int          nrows;
        int          made;
        bit          open_start;
        bit          sel;
        bit          rev;
        logic [31:0] coord;
        ncols = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 160)
                                             : $urandom_range(1, 12);
        nrows = (ncols > 12) ? 1 : $urandom_range(1, 4);
        open_start = ($urandom_range(0, 11) == 0);
        made = 0;
        for (int r = 0; r < nrows; r++)
        begin
            sel = ($urandom_range(0, 9) < 7);
            rev = 1'($urandom_range(0, 1));
            coord = ($urandom_range(0, 19) == 0) ? $urandom
                                                  : base + $urandom_range(0, 48) - 24;
            for (int c = 0; c < ncols; c++)
            begin
                queue_char(made == 0 && !open_start, r == nrows - 1 && c == ncols - 1,
                           sel, c == 0, coord, rev, $urandom_range(0, 3) == 0, c);
                made++;
            end
        end
        return made;
    endfunction

    // Characters with every field random, columns anywhere in the block.
    function automatic int queue_noise(input int n);
        logic [63:0] raw;
        in_beat_t    b;
        for (int i = 0; i < n; i++)
        begin
            raw = {$urandom, $urandom};
            b = raw[$bits(in_beat_t)-1:0];
            queue_char(b.block_first, $urandom_range(0, 3) == 0, b.row_selected,
                       b.row_first, b.row_coord, b.reverse_strand, b.is_gap,
                       int'(b.column));
        end
        return n;
    endfunction

    function automatic void queue_phase(input logic [31:0] base, input int budget);
        int made;
        made = 0;
        while (made < budget)
        begin
            if ($urandom_range(0, 9) == 0)
                made += queue_noise($urandom_range(1, 6));
            else
                made += queue_block(base);
        end
    endfunction

    // Wait until every queued character is taken and every summary is seen,
    // then let the pipeline settle. Returns at a falling edge.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (char_queue.size() != 0 || in_valid || pending_summaries.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_target(input logic [31:0] lo, input logic [31:0] hi);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_TARGET_START;
        cfg_data <= lo;
        @(posedge clk);
        cfg_index <= REG_TARGET_STOP;
        cfg_data <= hi;
        @(posedge clk);
        cfg_write <= 1'b0;
        tgt_start = lo;
        tgt_stop = hi;
        settings_used++;
        @(negedge clk);
    endtask

    // Input driver: record the beat taken at this edge, then offer the next
    // character once the slot is free and any chosen gap has run out.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_beat <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                track_char(in_beat);
                chars_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (char_queue.size() != 0)
                begin
                    in_beat <= char_queue.pop_front();
                    in_valid <= 1'b1;
                    gap_left <= calm ? 0 : pick_pause();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: compare each summary beat with the oldest prediction
    // and choose the stall for the next cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_summaries.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: summary beat with none expected, actual %p", $time,
                             out_beat);
                end
                else
                begin
                    oldest_summary = pending_summaries.pop_front();
                    summaries_checked++;
                    if (out_beat != oldest_summary)
                    begin
                        mismatches++;
                        $display("%0t: summary mismatch, expected %p, actual %p", $time,
                                 oldest_summary, out_beat);
                    end
                end
            end
            if (calm)
                out_stall <= 1'b0;
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_roll = pick_pause();
                stall_left <= stall_roll;
                out_stall <= (stall_roll != 0);
            end
        end
    end

    // Hang detection: too many cycles in a row with no beat on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, HANG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int          round;
        logic [31:0] spot;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] base;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed blocks against the window 100..200.
        write_target(32'd100, 32'd200);
        // Single character inside the window: whole block kept.
        queue_char(1, 1, 1, 1, 32'd150, 0, 0, 0);
        // Nothing reaches the window: block dropped.
        queue_char(1, 0, 1, 1, 32'd5, 0, 0, 0);
        queue_char(0, 0, 1, 0, 32'd0, 0, 0, 1);
        queue_char(0, 1, 1, 0, 32'd0, 0, 0, 2);
        // Forward row with a gap, then a reverse row hitting those columns and the gap's column.
        queue_char(1, 0, 1, 1, 32'd99, 0, 0, 0);
        queue_char(0, 0, 1, 0, 32'd0, 0, 0, 1);
        queue_char(0, 0, 1, 0, 32'd0, 0, 1, 2);
        queue_char(0, 0, 1, 0, 32'd0, 0, 0, 3);
        queue_char(0, 0, 1, 1, 32'd201, 1, 0, 0);
        queue_char(0, 0, 1, 0, 32'd0, 1, 0, 1);
        queue_char(0, 0, 1, 0, 32'd0, 1, 0, 2);
        queue_char(0, 1, 1, 0, 32'd0, 1, 0, 3);
        // Highest column index on its own.
        queue_char(1, 1, 1, 1, 32'd100, 0, 0, COL_SPAN - 1);
        // Position loaded by an unselected row start, then used by a selected one.
        queue_char(1, 0, 0, 1, 32'd200, 0, 0, 0);
        queue_char(0, 1, 1, 0, 32'd0, 0, 0, 1);
        // Block without its start marker keeps the previous counts.
        queue_char(0, 1, 1, 1, 32'd150, 1, 0, 5);
        // Only unselected and gap characters.
        queue_char(1, 0, 0, 1, 32'd150, 0, 0, 0);
        queue_char(0, 1, 1, 0, 32'd0, 0, 1, 1);
        wait_idle();

        // Reverse row running below zero against a window at the origin.
        write_target(32'd0, 32'd3);
        queue_char(1, 0, 1, 1, 32'd1, 1, 0, 0);
        queue_char(0, 0, 1, 0, 32'd0, 1, 0, 1);
        queue_char(0, 0, 1, 0, 32'd0, 1, 0, 2);
        queue_char(0, 1, 1, 0, 32'd0, 1, 0, 3);

        // Random blocks, cycling through window settings including the extremes.
        round = 0;
        while (items_queued < 850 || summaries_queued < 40)
        begin
            spot = $urandom_range(1000, 32'hFFFF0000);
            case (round % 6)
                0:
                begin
                    lo = 32'd0;
                    hi = 32'd0;
                    base = 32'd0;
                end
                1:
                begin
                    lo = 32'd0;
                    hi = 32'hFFFF_FFFF;
                    base = $urandom;
                end
                2:
                begin
                    lo = 32'hFFFF_FFFF;
                    hi = 32'hFFFF_FFFF;
                    base = 32'hFFFF_FFF0;
                end
                3:
                begin
                    lo = spot;
                    hi = spot + 32'd20;
                    base = spot;
                end
                4:
                begin
                    lo = 32'd500;
                    hi = 32'd400;
                    base = 32'd450;
                end
                default:
                begin
                    lo = spot;
                    hi = spot + 32'd5;
                    base = spot + 32'd2;
                end
            endcase
            wait_idle();
            write_target(lo, hi);
            // Every fourth phase runs with no gaps and no stalls.
            calm = (round % 4 == 3);
            queue_phase(base, 140);
            round++;
        end
        wait_idle();

        $display("Ran %0d characters under %0d target windows.", chars_taken, settings_used);
        $display("Checked %0d block summaries, %0d mismatches.", summaries_checked,
                 mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
design/arcm_pkg.sv
design/arcm_mark_store.sv
design/alignment_region_column_mask.sv
test/tb_alignment_region_column_mask.sv
